@@ hw/rtl/rrs_pkg.sv @@
package rrs_pkg;

   localparam int NODES      = 8;
   localparam int NODE_W     = 3;
   localparam int ADDR_W     = 2 * NODE_W;
   localparam int DEPTH      = NODES * NODES;
   localparam int MAX_ROUTES = 4;
   localparam int ROUTE_W    = 3;
   localparam int BW_W       = 32;
   localparam int PEN_W      = 15;
   localparam int MASK_W     = 8;
   localparam int PADDR_W    = 3;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam logic REG_ACTIVE  = 1'b0;
   localparam logic REG_PENALTY = 1'b1;

   localparam logic [MASK_W-1:0] ACTIVE_RESET  = 8'hFF;
   localparam logic [PEN_W-1:0]  PENALTY_RESET = 15'd3277;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIR_RD,
      ST_DIR_LD,
      ST_S1_RD,
      ST_T2_RA,
      ST_T2_HA,
      ST_T2_RD,
      ST_MIN,
      ST_MUL,
      ST_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  mem_we;
      logic [ADDR_W-1:0]     addr_a;
      logic [ADDR_W-1:0]     addr_b;
      logic                  ld_best;
      logic                  ld_ia;
      logic                  do_min;
      logic                  do_mul;
      logic                  do_cmp;
      logic                  mode2;
      logic [NODE_W-1:0]     relay_a;
      logic [NODE_W-1:0]     relay_b;
      logic                  emit;
      logic [NODE_W-1:0]     row;
      logic [NODE_W-1:0]     col;
      logic                  last;
   } cmd_type;

   typedef struct packed {
      logic              out_free;
      logic [MASK_W-1:0] active;
   } status_type;

endpackage

@@ hw/rtl/rrs_ctrl.sv @@
module rrs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [rrs_pkg::NODE_W-1:0] req_row_node,
   input  logic [rrs_pkg::NODE_W-1:0] req_col_node,
   input  rrs_pkg::status_type      status,
   output rrs_pkg::cmd_type         cmd
);

   rrs_pkg::state_type state_ff, state_in;
   logic [rrs_pkg::NODE_W-1:0] i_ff, i_in, j_ff, j_in, a_ff, a_in, b_ff, b_in;
   logic mode_ff, mode_in;
   logic pair_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrs_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         mode_ff  <= mode_in;
      end
   end

   assign pair_last = (i_ff == rrs_pkg::LAST_NODE) && (j_ff == rrs_pkg::LAST_NODE);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      mode_in   = mode_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mode2   = mode_ff;
      cmd.relay_a = a_ff;
      cmd.relay_b = b_ff;
      cmd.row     = i_ff;
      cmd.col     = j_ff;
      cmd.last    = pair_last;
      unique case (state_ff)
         rrs_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.addr_a = {req_row_node, req_col_node};
            if (req_valid) begin
               if (req_kind == rrs_pkg::KIND_LOAD) begin
                  cmd.mem_we = 1'b1;
               end else begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = rrs_pkg::ST_DIR_RD;
               end
            end
         end
         rrs_pkg::ST_DIR_RD: begin
            cmd.addr_a = {i_ff, j_ff};
            state_in   = rrs_pkg::ST_DIR_LD;
         end
         rrs_pkg::ST_DIR_LD: begin
            cmd.ld_best = 1'b1;
            a_in        = '0;
            state_in    = (i_ff == j_ff) ? rrs_pkg::ST_EMIT : rrs_pkg::ST_S1_RD;
         end
         rrs_pkg::ST_S1_RD: begin
            if (a_ff == i_ff || a_ff == j_ff || !status.active[a_ff]) begin
               if (a_ff == rrs_pkg::LAST_NODE) begin
                  a_in     = '0;
                  state_in = rrs_pkg::ST_T2_RA;
               end else begin
                  a_in = a_ff + 1'b1;
               end
            end else begin
               cmd.addr_a = {i_ff, a_ff};
               cmd.addr_b = {a_ff, j_ff};
               mode_in    = 1'b0;
               state_in   = rrs_pkg::ST_MIN;
            end
         end
         rrs_pkg::ST_T2_RA: begin
            if (a_ff == i_ff || a_ff == j_ff) begin
               if (a_ff == rrs_pkg::LAST_NODE) begin
                  state_in = rrs_pkg::ST_EMIT;
               end else begin
                  a_in = a_ff + 1'b1;
               end
            end else begin
               cmd.addr_a = {i_ff, a_ff};
               state_in   = rrs_pkg::ST_T2_HA;
            end
         end
         rrs_pkg::ST_T2_HA: begin
            cmd.ld_ia = 1'b1;
            b_in      = '0;
            state_in  = rrs_pkg::ST_T2_RD;
         end
         rrs_pkg::ST_T2_RD: begin
            if (b_ff == i_ff || b_ff == j_ff || b_ff == a_ff) begin
               if (b_ff == rrs_pkg::LAST_NODE) begin
                  if (a_ff == rrs_pkg::LAST_NODE) begin
                     state_in = rrs_pkg::ST_EMIT;
                  end else begin
                     a_in     = a_ff + 1'b1;
                     state_in = rrs_pkg::ST_T2_RA;
                  end
               end else begin
                  b_in = b_ff + 1'b1;
               end
            end else begin
               cmd.addr_a = {a_ff, b_ff};
               cmd.addr_b = {b_ff, j_ff};
               mode_in    = 1'b1;
               state_in   = rrs_pkg::ST_MIN;
            end
         end
         rrs_pkg::ST_MIN: begin
            cmd.do_min = 1'b1;
            state_in   = rrs_pkg::ST_MUL;
         end
         rrs_pkg::ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = rrs_pkg::ST_CMP;
         end
         rrs_pkg::ST_CMP: begin
            cmd.do_cmp = 1'b1;
            if (!mode_ff) begin
               if (a_ff == rrs_pkg::LAST_NODE) begin
                  a_in     = '0;
                  state_in = rrs_pkg::ST_T2_RA;
               end else begin
                  a_in     = a_ff + 1'b1;
                  state_in = rrs_pkg::ST_S1_RD;
               end
            end else if (b_ff == rrs_pkg::LAST_NODE) begin
               if (a_ff == rrs_pkg::LAST_NODE) begin
                  state_in = rrs_pkg::ST_EMIT;
               end else begin
                  a_in     = a_ff + 1'b1;
                  state_in = rrs_pkg::ST_T2_RA;
               end
            end else begin
               b_in     = b_ff + 1'b1;
               state_in = rrs_pkg::ST_T2_RD;
            end
         end
         rrs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (pair_last) begin
                  state_in = rrs_pkg::ST_IDLE;
               end else begin
                  if (j_ff == rrs_pkg::LAST_NODE) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
                  state_in = rrs_pkg::ST_DIR_RD;
               end
            end
         end
         default: state_in = rrs_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/rrs_datapath.sv @@
module rrs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rrs_pkg::cmd_type              cmd,
   output rrs_pkg::status_type           status,
   input  logic [rrs_pkg::BW_W-1:0]      req_link_bandwidth,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_pair_row,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_pair_col,
   output logic [rrs_pkg::BW_W-1:0]      rsp_effective_bandwidth,
   output logic [1:0]                    rsp_hop_count,
   output logic [rrs_pkg::ROUTE_W-1:0]   rsp_route_count,
   output logic [rrs_pkg::MASK_W-1:0]    rsp_tie_relay_mask,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_first_relay,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_second_relay,
   output logic                          rsp_last
);

   localparam int PROD_W = rrs_pkg::BW_W + rrs_pkg::PEN_W + 1;

   logic [rrs_pkg::BW_W-1:0] mem [rrs_pkg::DEPTH];
   logic [rrs_pkg::BW_W-1:0] rda_ff, rdb_ff, ia_ff, m_ff, best_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [rrs_pkg::MASK_W-1:0] active_ff;
   logic [rrs_pkg::PEN_W-1:0]  pen_ff;
   logic [1:0]                 hops_ff;
   logic [rrs_pkg::ROUTE_W-1:0] routes_ff;
   logic [rrs_pkg::MASK_W-1:0]  tmask_ff;
   logic [rrs_pkg::NODE_W-1:0]  r0_ff, r1_ff;
   logic                        out_valid_ff;

   logic [rrs_pkg::BW_W-1:0] min_ab, min_v, v;
   logic [rrs_pkg::PEN_W:0]  frac;
   logic                     wr;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[cmd.addr_a] <= req_link_bandwidth;
      end
      rda_ff <= mem[cmd.addr_a];
      rdb_ff <= mem[cmd.addr_b];
   end

   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= rrs_pkg::ACTIVE_RESET;
         pen_ff    <= rrs_pkg::PENALTY_RESET;
      end else if (wr) begin
         unique case (paddr[2])
            rrs_pkg::REG_ACTIVE:  active_ff <= pwdata[rrs_pkg::MASK_W-1:0];
            rrs_pkg::REG_PENALTY: pen_ff    <= pwdata[rrs_pkg::PEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         rrs_pkg::REG_ACTIVE:  prdata = 32'(active_ff);
         rrs_pkg::REG_PENALTY: prdata = 32'(pen_ff);
         default:              prdata = '0;
      endcase
   end

   assign min_ab = (rda_ff < rdb_ff) ? rda_ff : rdb_ff;
   assign min_v  = (cmd.mode2 && ia_ff < min_ab) ? ia_ff : min_ab;
   // two relays pay twice the penalty
   assign frac   = cmd.mode2 ? {pen_ff, 1'b0} : {1'b0, pen_ff};
   assign v      = m_ff - prod_ff[PROD_W-1:16];

   always_ff @(posedge clock) begin
      if (cmd.ld_ia)  ia_ff   <= rda_ff;
      if (cmd.do_min) m_ff    <= min_v;
      if (cmd.do_mul) prod_ff <= m_ff * frac;
      if (cmd.ld_best) begin
         best_ff   <= rda_ff;
         hops_ff   <= 2'd0;
         routes_ff <= '0;
         tmask_ff  <= '0;
         r0_ff     <= '0;
         r1_ff     <= '0;
      end else if (cmd.do_cmp) begin
         if (v > best_ff) begin
            best_ff   <= v;
            routes_ff <= rrs_pkg::ROUTE_W'(1);
            if (cmd.mode2) begin
               hops_ff <= 2'd2;
               r0_ff   <= cmd.relay_b;
               r1_ff   <= cmd.relay_a;
            end else begin
               hops_ff  <= 2'd1;
               r0_ff    <= cmd.relay_a;
               tmask_ff <= rrs_pkg::MASK_W'(1) << cmd.relay_a;
            end
         end else if (!cmd.mode2 && v == best_ff &&
                      routes_ff < rrs_pkg::ROUTE_W'(rrs_pkg::MAX_ROUTES)) begin
            routes_ff <= routes_ff + 1'b1;
            tmask_ff  <= tmask_ff | (rrs_pkg::MASK_W'(1) << cmd.relay_a);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pair_row            <= cmd.row;
         rsp_pair_col            <= cmd.col;
         rsp_effective_bandwidth <= best_ff;
         rsp_hop_count           <= hops_ff;
         rsp_route_count         <= (hops_ff == 2'd0) ? '0 : routes_ff;
         rsp_tie_relay_mask      <= (hops_ff == 2'd1) ? tmask_ff : '0;
         rsp_first_relay         <= (hops_ff == 2'd0) ? '0 : r0_ff;
         rsp_second_relay        <= (hops_ff == 2'd2) ? r1_ff : '0;
         rsp_last                <= cmd.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.active   = active_ff;

endmodule

@@ hw/rtl/relay_route_selector_top.sv @@
// load beat: taken while idle, back to back, no result
// start beat: 64 pair results; each pair reads its direct link, scores each active single relay,
//   skips the other relays, then for each two-relay first node scores each relay pair in turn,
//   and waits for the result register before it emits (one shared min / multiply / compare)
// reset: control idle, active_mask 255, penalty 3277, matrix contents undefined
module relay_route_selector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [rrs_pkg::NODE_W-1:0]    req_row_node,
   input  logic [rrs_pkg::NODE_W-1:0]    req_col_node,
   input  logic [rrs_pkg::BW_W-1:0]      req_link_bandwidth,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_pair_row,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_pair_col,
   output logic [rrs_pkg::BW_W-1:0]      rsp_effective_bandwidth,
   output logic [1:0]                    rsp_hop_count,
   output logic [rrs_pkg::ROUTE_W-1:0]   rsp_route_count,
   output logic [rrs_pkg::MASK_W-1:0]    rsp_tie_relay_mask,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_first_relay,
   output logic [rrs_pkg::NODE_W-1:0]    rsp_second_relay,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   rrs_pkg::cmd_type    cmd;
   rrs_pkg::status_type status;

   assign pready = 1'b1;

   rrs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_row_node (req_row_node),
      .req_col_node (req_col_node),
      .status       (status),
      .cmd          (cmd)
   );

   rrs_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_link_bandwidth      (req_link_bandwidth),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_pair_row            (rsp_pair_row),
      .rsp_pair_col            (rsp_pair_col),
      .rsp_effective_bandwidth (rsp_effective_bandwidth),
      .rsp_hop_count           (rsp_hop_count),
      .rsp_route_count         (rsp_route_count),
      .rsp_tie_relay_mask      (rsp_tie_relay_mask),
      .rsp_first_relay         (rsp_first_relay),
      .rsp_second_relay        (rsp_second_relay),
      .rsp_last                (rsp_last)
   );

endmodule
